@@ hw/rtl/sstf_pkg.sv @@
// Shared constants, types and state encoding for the SSTF disk scheduler.
`timescale 1ns / 1ps

package sstf_pkg;

    localparam int MAX_REQUESTS = 16;
    localparam int CYL_BITS     = 16;
    localparam int SEEK_W       = 20;
    localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_RUN  = 1'b1;

    // Best candidate found so far, handed from cell to cell.
    typedef struct packed {
        logic                found;
        logic [CYL_BITS-1:0] seek_dist;
        logic [IDX_W-1:0]    idx;
        logic [CYL_BITS-1:0] cyl;
    } cand_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic [CYL_BITS-1:0] head;
        logic                load;
        logic [IDX_W-1:0]    load_idx;
        logic [CYL_BITS-1:0] load_cyl;
        logic                mark;
        logic [IDX_W-1:0]    mark_idx;
        logic                clear;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OUT,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

@@ hw/rtl/sstf_cell.sv @@
// One request slot of the scheduler chain with its nearest-candidate compare stage.
`timescale 1ns / 1ps

module sstf_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [sstf_pkg::IDX_W-1:0]       my_idx,
    input  sstf_pkg::cell_ctrl_t             ctrl,
    input  sstf_pkg::cand_t                  cand_in,
    output sstf_pkg::cand_t                  cand_out
);

    logic [sstf_pkg::CYL_BITS-1:0] cyl_reg;
    logic                          occupied_reg;
    logic                          served_reg;
    sstf_pkg::cand_t               cand_reg;
    sstf_pkg::cand_t               cand_next;
    logic [sstf_pkg::CYL_BITS-1:0] seek_dist;
    logic                          eligible;

    always_comb begin
        seek_dist = (ctrl.head >= cyl_reg) ? (ctrl.head - cyl_reg)
                                           : (cyl_reg - ctrl.head);
        eligible  = occupied_reg && !served_reg;
        cand_next = cand_in;
        // Strictly smaller only, so an earlier slot keeps a tie.
        if (eligible && (!cand_in.found || seek_dist < cand_in.seek_dist)) begin
            cand_next.found     = 1'b1;
            cand_next.seek_dist = seek_dist;
            cand_next.idx       = my_idx;
            cand_next.cyl       = cyl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_reg <= 1'b0;
            served_reg   <= 1'b0;
            cand_reg     <= '0;
        end else begin
            cand_reg <= cand_next;
            if (ctrl.clear) begin
                occupied_reg <= 1'b0;
                served_reg   <= 1'b0;
            end else if (ctrl.load && ctrl.load_idx == my_idx) begin
                occupied_reg <= 1'b1;
                served_reg   <= 1'b0;
            end else if (ctrl.mark && ctrl.mark_idx == my_idx) begin
                served_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load && ctrl.load_idx == my_idx) begin
            cyl_reg <= ctrl.load_cyl;
        end
    end

    assign cand_out = cand_reg;

endmodule

@@ hw/rtl/sstf_disk_scheduler_unit.sv @@
// Top level: request chain, run sequencer and result register of the SSTF scheduler.
// A load into a full table is dropped, and so is a run on an empty table.
// A run emits the start position, then each next position after a full pass of the
// candidate through the cell chain; a position waits while the output register is full.
// Input is not accepted again until the last position has entered the output register.
// Synchronous active-low reset empties the table; the cylinder storage is not reset.
`timescale 1ns / 1ps

module sstf_disk_scheduler_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [15:0] s_cylinder,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_head_position,
    output logic [19:0] m_total_seek,
    output logic [4:0]  m_step_index,
    output logic        m_last
);

    localparam int CB = sstf_pkg::CYL_BITS;
    localparam int SW = sstf_pkg::SEEK_W;
    localparam int IW = sstf_pkg::IDX_W;
    localparam int CW = sstf_pkg::CNT_W;

    sstf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CB-1:0]    head_reg, head_next;
    logic [SW-1:0]    total_reg, total_next;
    logic [CW-1:0]    step_reg, step_next;
    logic             last_reg, last_next;
    logic [IW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic             out_load;

    logic             m_valid_reg;
    logic [15:0]      m_head_reg;
    logic [19:0]      m_total_reg;
    logic [4:0]       m_step_reg;
    logic             m_last_reg;

    sstf_pkg::cell_ctrl_t ctrl;
    sstf_pkg::cand_t      cand [0:sstf_pkg::MAX_REQUESTS];
    sstf_pkg::cand_t      best;
    logic [SW:0]          sum;
    logic                 in_fire;

    assign cand[0] = '0;
    assign best    = cand[sstf_pkg::MAX_REQUESTS];

    genvar g;
    generate
        for (g = 0; g < sstf_pkg::MAX_REQUESTS; g++) begin : g_cell
            sstf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .my_idx   (IW'(g)),
                .ctrl     (ctrl),
                .cand_in  (cand[g]),
                .cand_out (cand[g+1])
            );
        end
    endgenerate

    assign s_ready = (state_reg == sstf_pkg::ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign sum     = {1'b0, total_reg} + (SW + 1)'(best.seek_dist);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        total_next     = total_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_load       = 1'b0;
        ctrl           = '0;
        ctrl.head      = head_reg;
        ctrl.load_idx  = count_reg[IW-1:0];
        ctrl.load_cyl  = s_cylinder[CB-1:0];
        ctrl.mark_idx  = best.idx;

        case (state_reg)
            sstf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_action == sstf_pkg::ACTION_LOAD) begin
                        if (count_reg < CW'(sstf_pkg::MAX_REQUESTS)) begin
                            ctrl.load  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (count_reg != '0) begin
                        head_next  = s_cylinder[CB-1:0];
                        total_next = '0;
                        step_next  = '0;
                        last_next  = 1'b0;
                        state_next = sstf_pkg::ST_OUT;
                    end
                end
            end
            sstf_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    if (last_reg) begin
                        ctrl.clear = 1'b1;
                        count_next = '0;
                        state_next = sstf_pkg::ST_IDLE;
                    end else begin
                        scan_cnt_next = '0;
                        state_next    = sstf_pkg::ST_SCAN;
                    end
                end
            end
            sstf_pkg::ST_SCAN: begin
                // Head and served flags are stable here; wait one full chain pass.
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IW'(sstf_pkg::MAX_REQUESTS - 1)) begin
                    state_next = sstf_pkg::ST_UPDATE;
                end
            end
            sstf_pkg::ST_UPDATE: begin
                ctrl.mark  = 1'b1;
                head_next  = best.cyl;
                total_next = sum[SW] ? sstf_pkg::SEEK_MAX : sum[SW-1:0];
                step_next  = step_reg + 1'b1;
                last_next  = (step_reg + 1'b1) == count_reg;
                state_next = sstf_pkg::ST_OUT;
            end
            default: begin
                state_next = sstf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sstf_pkg::ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            total_reg   <= '0;
            step_reg    <= '0;
            last_reg    <= 1'b0;
            scan_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            total_reg    <= total_next;
            step_reg     <= step_next;
            last_reg     <= last_next;
            scan_cnt_reg <= scan_cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_head_reg  <= 16'(head_reg);
            m_total_reg <= 20'(total_reg);
            m_step_reg  <= 5'(step_reg);
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_head_position = m_head_reg;
    assign m_total_seek    = m_total_reg;
    assign m_step_index    = m_step_reg;
    assign m_last          = m_last_reg;

    // The table is emptied as the final position of a run enters the output register.
    a_empty_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> (count_reg == '0))
        else $error("table not emptied after final position");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(sstf_pkg::MAX_REQUESTS))
        else $error("request count beyond table size");

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sstf_pkg::ST_IDLE) |-> (step_reg <= count_reg))
        else $error("step index beyond request count");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // Every scan that ends finds an unserved request.
    a_scan_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sstf_pkg::ST_UPDATE) |-> best.found)
        else $error("no candidate at end of scan");

endmodule
